// ----- rtl/core/des_pkg.sv -----
// Package for the DES block encryption core: permutation tables, S-boxes,
// rotation schedule and the combinational helper functions.
// No dependencies.
package des_pkg;

   localparam int RoundsDefault = 16;
   localparam int BlockWidth = 64;
   localparam int KeyWidth = 64;
   localparam int HalfKeyWidth = 28;

   typedef logic [63:0] word64_type;
   typedef logic [55:0] word56_type;
   typedef logic [47:0] word48_type;
   typedef logic [31:0] word32_type;

   typedef logic [5:0] map_entry_type;
   typedef logic [6:0] map64_entry_type;

   localparam map_entry_type PC2_MAP [48] = '{
      6'd14, 6'd17, 6'd11, 6'd24, 6'd1, 6'd5, 6'd3, 6'd28, 6'd15, 6'd6, 6'd21, 6'd10,
      6'd23, 6'd19, 6'd12, 6'd4, 6'd26, 6'd8, 6'd16, 6'd7, 6'd27, 6'd20, 6'd13, 6'd2,
      6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
      6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
   };

   localparam map64_entry_type PC1_MAP [56] = '{
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9, 7'd1, 7'd58, 7'd50, 7'd42, 7'd34,
      7'd26, 7'd18, 7'd10, 7'd2, 7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6, 7'd61, 7'd53, 7'd45, 7'd37,
      7'd29, 7'd21, 7'd13, 7'd5, 7'd28, 7'd20, 7'd12, 7'd4
   };

   localparam map64_entry_type IP_MAP [64] = '{
      7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
      7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
      7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
      7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
      7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9, 7'd1,
      7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
      7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
      7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
   };

   localparam map64_entry_type FP_MAP [64] = '{
      7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
      7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
      7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
      7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
      7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
      7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
      7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
      7'd33, 7'd1, 7'd41, 7'd9, 7'd49, 7'd17, 7'd57, 7'd25
   };

   localparam map_entry_type E_MAP [48] = '{
      6'd32, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd9,
      6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
      6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
      6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
   };

   localparam map_entry_type P_MAP [32] = '{
      6'd16, 6'd7, 6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
      6'd1, 6'd15, 6'd23, 6'd26, 6'd5, 6'd18, 6'd31, 6'd10,
      6'd2, 6'd8, 6'd24, 6'd14, 6'd32, 6'd27, 6'd3, 6'd9,
      6'd19, 6'd13, 6'd30, 6'd6, 6'd22, 6'd11, 6'd4, 6'd25
   };

   localparam logic [1:0] ROT_AMOUNT [16] = '{
      2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
      2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
   };

   localparam logic [3:0] SBOX [8][64] = '{
      '{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8, 4'd3, 4'd10, 4'd6, 4'd12,
        4'd5, 4'd9, 4'd0, 4'd7, 4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
        4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8, 4'd4, 4'd1, 4'd14, 4'd8,
        4'd13, 4'd6, 4'd2, 4'd11, 4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0,
        4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7, 4'd5, 4'd11, 4'd3, 4'd14,
        4'd10, 4'd0, 4'd6, 4'd13},
      '{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4, 4'd9, 4'd7, 4'd2, 4'd13,
        4'd12, 4'd0, 4'd5, 4'd10, 4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
        4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5, 4'd0, 4'd14, 4'd7, 4'd11,
        4'd10, 4'd4, 4'd13, 4'd1, 4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15,
        4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2, 4'd11, 4'd6, 4'd7, 4'd12,
        4'd0, 4'd5, 4'd14, 4'd9},
      '{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5, 4'd1, 4'd13, 4'd12, 4'd7,
        4'd11, 4'd4, 4'd2, 4'd8, 4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
        4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1, 4'd13, 4'd6, 4'd4, 4'd9,
        4'd8, 4'd15, 4'd3, 4'd0, 4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7,
        4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7, 4'd4, 4'd15, 4'd14, 4'd3,
        4'd11, 4'd5, 4'd2, 4'd12},
      '{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10, 4'd1, 4'd2, 4'd8, 4'd5,
        4'd11, 4'd12, 4'd4, 4'd15, 4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
        4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9, 4'd10, 4'd6, 4'd9, 4'd0,
        4'd12, 4'd11, 4'd7, 4'd13, 4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4,
        4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8, 4'd9, 4'd4, 4'd5, 4'd11,
        4'd12, 4'd7, 4'd2, 4'd14},
      '{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6, 4'd8, 4'd5, 4'd3, 4'd15,
        4'd13, 4'd0, 4'd14, 4'd9, 4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
        4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6, 4'd4, 4'd2, 4'd1, 4'd11,
        4'd10, 4'd13, 4'd7, 4'd8, 4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14,
        4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13, 4'd6, 4'd15, 4'd0, 4'd9,
        4'd10, 4'd4, 4'd5, 4'd3},
      '{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8, 4'd0, 4'd13, 4'd3, 4'd4,
        4'd14, 4'd7, 4'd5, 4'd11, 4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
        4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8, 4'd9, 4'd14, 4'd15, 4'd5,
        4'd2, 4'd8, 4'd12, 4'd3, 4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6,
        4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10, 4'd11, 4'd14, 4'd1, 4'd7,
        4'd6, 4'd0, 4'd8, 4'd13},
      '{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13, 4'd3, 4'd12, 4'd9, 4'd7,
        4'd5, 4'd10, 4'd6, 4'd1, 4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
        4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6, 4'd1, 4'd4, 4'd11, 4'd13,
        4'd12, 4'd3, 4'd7, 4'd14, 4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2,
        4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7, 4'd9, 4'd5, 4'd0, 4'd15,
        4'd14, 4'd2, 4'd3, 4'd12},
      '{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1, 4'd10, 4'd9, 4'd3, 4'd14,
        4'd5, 4'd0, 4'd12, 4'd7, 4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
        4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2, 4'd7, 4'd11, 4'd4, 4'd1,
        4'd9, 4'd12, 4'd14, 4'd2, 4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8,
        4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13, 4'd15, 4'd12, 4'd9, 4'd0,
        4'd3, 4'd5, 4'd6, 4'd11}
   };

   // Bit positions in the tables count from the most significant bit, starting at 1.
   function automatic word56_type pc1(input word64_type k);
      word56_type r;
      for (int i = 0; i < 56; i++) begin
         r[55 - i] = k[64 - int'(PC1_MAP[i])];
      end
      return r;
   endfunction

   function automatic word48_type pc2(input word56_type cd);
      word48_type r;
      for (int i = 0; i < 48; i++) begin
         r[47 - i] = cd[56 - int'(PC2_MAP[i])];
      end
      return r;
   endfunction

   function automatic word64_type ip(input word64_type b);
      word64_type r;
      for (int i = 0; i < 64; i++) begin
         r[63 - i] = b[64 - int'(IP_MAP[i])];
      end
      return r;
   endfunction

   function automatic word64_type fp(input word64_type b);
      word64_type r;
      for (int i = 0; i < 64; i++) begin
         r[63 - i] = b[64 - int'(FP_MAP[i])];
      end
      return r;
   endfunction

   function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
      logic [27:0] r;
      r = (s == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
      return r;
   endfunction

   function automatic word32_type feistel(input word32_type rh, input word48_type k);
      word48_type x;
      word32_type s;
      word32_type r;
      logic [5:0] b;
      for (int i = 0; i < 48; i++) begin
         x[47 - i] = rh[32 - int'(E_MAP[i])];
      end
      x = x ^ k;
      for (int i = 0; i < 8; i++) begin
         b = x[47 - 6 * i -: 6];
         s[31 - 4 * i -: 4] = SBOX[i][{b[5], b[0], b[4:1]}];
      end
      for (int i = 0; i < 32; i++) begin
         r[31 - i] = s[32 - int'(P_MAP[i])];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/des_block_encrypt.sv -----
// Top level of the pipelined DES block encryption core.
// Depends on des_pkg for tables and round functions.
//
// Usage: the key is written through csr_wr_en / csr_wr_data while the core
// is idle; the key schedule is computed from the key register into per-round
// key registers, so a written key takes effect through both registers in turn.
// Plaintext words enter on req_valid / req_stall, ciphertext words leave on
// rsp_valid / rsp_stall.
// The pipeline has one register stage for the initial permutation, one per
// Feistel round and one output stage. One word is accepted every cycle while
// req_stall is low; the round stage count sets the latency and the single
// round per stage sets the clock rate.
// When the receiver stalls, words keep moving forward into empty stages and
// req_stall rises only once the whole pipeline is full, so nothing is lost
// or repeated. Reset clears all valid bits and sets the key to zero.
module des_block_encrypt #(
   parameter int ROUNDS = des_pkg::RoundsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_plaintext_block,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_ciphertext_block,
   input  logic        csr_wr_en,
   input  logic [63:0] csr_wr_data
);

   localparam int Stages = ROUNDS + 2;

   logic [63:0] key_ff;
   des_pkg::word56_type cd_init;
   logic [27:0] c_sched [ROUNDS + 1];
   logic [27:0] d_sched [ROUNDS + 1];
   logic [47:0] rk_ff [ROUNDS];

   logic [Stages-1:0] valid_ff;
   logic [Stages-1:0] valid_in;
   logic [Stages-1:0] adv;
   logic [31:0] l_ff [ROUNDS + 1];
   logic [31:0] r_ff [ROUNDS + 1];
   logic [63:0] out_ff;
   logic [63:0] ip_blk;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en) begin
         key_ff <= csr_wr_data;
      end
   end

   assign cd_init = des_pkg::pc1(key_ff);
   assign c_sched[0] = cd_init[55:28];
   assign d_sched[0] = cd_init[27:0];

   for (genvar g = 0; g < ROUNDS; g++) begin : g_keys
      assign c_sched[g + 1] = des_pkg::rot28(c_sched[g], des_pkg::ROT_AMOUNT[g % 16]);
      assign d_sched[g + 1] = des_pkg::rot28(d_sched[g], des_pkg::ROT_AMOUNT[g % 16]);
      always_ff @(posedge clock) begin
         rk_ff[g] <= des_pkg::pc2({c_sched[g + 1], d_sched[g + 1]});
      end
   end

   // A stage moves when the next one is empty or moves itself.
   always_comb begin
      adv[Stages - 1] = !valid_ff[Stages - 1] || !rsp_stall;
      for (int i = Stages - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i + 1];
      end
   end

   assign req_stall = !adv[0];

   always_comb begin
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < Stages; i++) begin
         if (adv[i]) begin
            valid_in[i] = valid_ff[i - 1];
         end else begin
            valid_in[i] = valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ip_blk = des_pkg::ip(req_plaintext_block);

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         l_ff[0] <= ip_blk[63:32];
         r_ff[0] <= ip_blk[31:0];
      end
   end

   for (genvar g = 0; g < ROUNDS; g++) begin : g_rounds
      always_ff @(posedge clock) begin
         if (adv[g + 1]) begin
            l_ff[g + 1] <= r_ff[g];
            r_ff[g + 1] <= l_ff[g] ^ des_pkg::feistel(r_ff[g], rk_ff[g]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[Stages - 1]) begin
         out_ff <= des_pkg::fp({r_ff[ROUNDS], l_ff[ROUNDS]});
      end
   end

   assign rsp_valid = valid_ff[Stages - 1];
   assign rsp_ciphertext_block = out_ff;

endmodule

// ----- rtl/core/des_block_encrypt_checker.sv -----
// Port-level checker for the DES block encryption core, bound to the top level.
// Depends only on the top level's ports.
module des_block_encrypt_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_ciphertext_block
);

   // A stalled result word holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ciphertext_block))
      else $error("stalled result word changed");

   // The input is stalled only while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // Nothing comes out right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   // Reset leaves the input ready.
   assert property (@(posedge clock) $past(reset) |-> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind des_block_encrypt des_block_encrypt_checker u_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_ciphertext_block(rsp_ciphertext_block)
);
